// ===== design/affine_vector_transform_macros.svh =====
// Assertion macros shared by the affine vector transform RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef AFFINE_VECTOR_TRANSFORM_MACROS_SVH
`define AFFINE_VECTOR_TRANSFORM_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define AVT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted
`define AVT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold on the cycle after reset is sampled
`define AVT_ASSERT_RST(label, clk, rstn, cons, msg) \
    label: assert property (@(posedge clk) !(rstn) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/avt_pkg.sv =====
// Shared types and constants for the affine vector transform block.
// No dependencies; imported by the coefficient bank, the dot lane and the top level.
package avt_pkg;

    // Default fixed-point format (signed Q16.16)
    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // Coefficient slots per matrix: four rows of three columns
    localparam int NUM_COEFFS = 12;
    localparam int IDX_W      = 4;
    localparam int FUNC_W     = 3;
    localparam int NUM_LANES  = 3;

    // Request kinds carried on tuser
    localparam logic [FUNC_W-1:0] FUNC_LOAD_FWD = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_INV = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_FWD_PNT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_INV_PNT  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_FWD_DIR  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_INV_DIR  = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_NORMAL   = 3'd6;

    // Coefficient write request towards the bank
    typedef struct packed {
        logic             wr_en;
        logic             inverse;
        logic [IDX_W-1:0] index;
    } avt_coeff_wr_t;

    // Per-stage load enables for the arithmetic lanes
    typedef struct packed {
        logic ld_op;
        logic ld_prod;
        logic ld_sum;
    } avt_stage_en_t;

endpackage

// ===== design/affine_vector_transform.sv =====
// Top level of the affine vector transform: stream ports, pipeline control.
// Depends on avt_pkg, avt_coeff_bank, avt_dot_lane and the assertion macro header.
//
// Usage
//   Requests arrive on the s_ channel; tuser carries the request kind, tdata the
//   coefficient slot, the coefficient and the x, y, z vector. Load requests write
//   one slot of the forward or inverse matrix at the accepting edge and give no
//   result. Point, direction and normal requests each give one saturated x, y, z
//   result on the m_ channel, in request order.
//   Throughput: one request per cycle while the receiver keeps taking results; the
//   five stages (input, operand select, multiply, sum, output) each hold one request,
//   and load requests take no stage slot.
//   A load is seen by every transform accepted after it.
//   Reset (aresetn low at a clock edge) empties the pipeline and sets both
//   matrices to identity.
//   When the receiver stalls, the output register holds its result; stages
//   behind it keep filling any empty slot, and s_tready drops only once the
//   first stage is full and cannot move on.
`include "affine_vector_transform_macros.svh"

module affine_vector_transform #(
    parameter int FRAC_BITS  = avt_pkg::DEF_FRAC_BITS,
    parameter int DATA_WIDTH = avt_pkg::DEF_DATA_WIDTH,
    parameter int S_TDATA_W  = ((avt_pkg::IDX_W + 4 * DATA_WIDTH + 7) / 8) * 8,
    parameter int M_TDATA_W  = ((3 * DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // entry_index, coeff_value, in_x, in_y, in_z, zero pad
    input  logic [S_TDATA_W-1:0]          s_tdata,
    // func
    input  logic [avt_pkg::FUNC_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_x, out_y, out_z, zero pad
    output logic [M_TDATA_W-1:0]          m_tdata
);
    import avt_pkg::*;

    localparam int COEFF_LO = IDX_W;
    localparam int VEC_LO   = IDX_W + DATA_WIDTH;
    localparam int PAYLOAD_W = 3 * DATA_WIDTH;

    // Request fields
    logic [FUNC_W-1:0]           in_func;
    logic [IDX_W-1:0]            in_index;
    logic [DATA_WIDTH-1:0]       in_coeff;
    logic [2:0][DATA_WIDTH-1:0]  in_vec;
    logic                        accept;
    logic                        is_load;
    logic                        is_xform;

    // Stage valids and readiness
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready, out_ready;

    logic [FUNC_W-1:0]           s1_func_reg;
    logic [2:0][DATA_WIDTH-1:0]  s1_vec_reg;

    avt_coeff_wr_t               coeff_wr;
    avt_stage_en_t               lane_en;
    logic [2:0][2:0][DATA_WIDTH-1:0] sel_coeff;
    logic [2:0][DATA_WIDTH-1:0]  sel_offset;
    logic                        sel_use_offset;
    logic [2:0][DATA_WIDTH-1:0]  lane_result;
    logic [PAYLOAD_W-1:0]        out_data_reg;

    // Unpack request
    assign in_func  = s_tuser;
    assign in_index = s_tdata[IDX_W-1:0];
    assign in_coeff = s_tdata[COEFF_LO +: DATA_WIDTH];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            in_vec[j] = s_tdata[VEC_LO + j*DATA_WIDTH +: DATA_WIDTH];
        end
    end

    assign accept   = s_tvalid && s_tready;
    assign is_load  = (in_func == FUNC_LOAD_FWD) || (in_func == FUNC_LOAD_INV);
    assign is_xform = (in_func >= FUNC_FWD_PNT) && (in_func <= FUNC_NORMAL);

    // Backpressure chain, output side first
    assign out_ready = !out_valid_reg || m_tready;
    assign s4_ready  = !s4_valid_reg || out_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= accept && is_xform;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready) begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    // Input stage payload
    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_func_reg <= in_func;
            s1_vec_reg  <= in_vec;
        end
    end

    // Coefficient writes happen at the accepting edge
    assign coeff_wr.wr_en   = accept && is_load;
    assign coeff_wr.inverse = (in_func == FUNC_LOAD_INV);
    assign coeff_wr.index   = in_index;

    avt_coeff_bank #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_bank (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr         (coeff_wr),
        .wr_value   (in_coeff),
        .func       (s1_func_reg),
        .coeff      (sel_coeff),
        .offset     (sel_offset),
        .use_offset (sel_use_offset)
    );

    assign lane_en.ld_op   = s2_ready;
    assign lane_en.ld_prod = s3_ready;
    assign lane_en.ld_sum  = s4_ready;

    for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
        avt_dot_lane #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .aclk       (aclk),
            .en         (lane_en),
            .vec        (s1_vec_reg),
            .coeff      (sel_coeff[c]),
            .offset     (sel_offset[c]),
            .use_offset (sel_use_offset),
            .result     (lane_result[c])
        );
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (out_ready) begin
            out_data_reg <= lane_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg);

    // Checks
    `AVT_ASSERT_NXT(a_load_no_result, aclk, aresetn, accept && is_load, !s1_valid_reg, "load took a slot")
    `AVT_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !s1_valid_reg, s_tready, "empty stage stalled")
    `AVT_ASSERT_RST(a_reset_empties, aclk, aresetn, !m_tvalid && !s1_valid_reg, "busy after reset")

endmodule

// ===== design/avt_coeff_bank.sv =====
// Forward and inverse 4x3 coefficient matrices with operand selection.
// Depends on avt_pkg; feeds the three dot lanes of the top level.
module avt_coeff_bank #(
    parameter int DATA_WIDTH = avt_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = avt_pkg::DEF_FRAC_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  avt_pkg::avt_coeff_wr_t               wr,
    input  logic [DATA_WIDTH-1:0]                wr_value,
    input  logic [avt_pkg::FUNC_W-1:0]           func,
    output logic [2:0][2:0][DATA_WIDTH-1:0]      coeff,
    output logic [2:0][DATA_WIDTH-1:0]           offset,
    output logic                                 use_offset
);
    import avt_pkg::*;

    localparam logic [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1) << FRAC_BITS;

    logic [DATA_WIDTH-1:0] fwd_reg [NUM_COEFFS];
    logic [DATA_WIDTH-1:0] inv_reg [NUM_COEFFS];
    logic                  use_inv;
    logic                  is_normal;

    // Reset to identity, write one slot per load request whose index is in range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEFFS; i++) begin
                fwd_reg[i] <= (i == 0 || i == 4 || i == 8) ? ONE : '0;
                inv_reg[i] <= (i == 0 || i == 4 || i == 8) ? ONE : '0;
            end
        end else if (wr.wr_en && (wr.index < IDX_W'(NUM_COEFFS))) begin
            if (wr.inverse) begin
                inv_reg[wr.index] <= wr_value;
            end else begin
                fwd_reg[wr.index] <= wr_value;
            end
        end
    end

    assign use_inv    = (func == FUNC_INV_PNT) || (func == FUNC_INV_DIR) ||
                        (func == FUNC_NORMAL);
    assign is_normal  = (func == FUNC_NORMAL);
    assign use_offset = (func == FUNC_FWD_PNT) || (func == FUNC_INV_PNT);

    // Route matrix entries to lanes: columns for points and directions,
    // rows of the inverse for normals
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int j = 0; j < 3; j++) begin
                if (is_normal) begin
                    coeff[c][j] = inv_reg[c*3 + j];
                end else begin
                    coeff[c][j] = use_inv ? inv_reg[j*3 + c] : fwd_reg[j*3 + c];
                end
            end
            offset[c] = use_inv ? inv_reg[9 + c] : fwd_reg[9 + c];
        end
    end

endmodule

// ===== design/avt_dot_lane.sv =====
// One output component: registered operands, three multipliers, adder, saturation.
// Depends on avt_pkg; three instances sit in the top level.
module avt_dot_lane #(
    parameter int DATA_WIDTH = avt_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = avt_pkg::DEF_FRAC_BITS
) (
    input  logic                       aclk,
    input  avt_pkg::avt_stage_en_t     en,
    input  logic [2:0][DATA_WIDTH-1:0] vec,
    input  logic [2:0][DATA_WIDTH-1:0] coeff,
    input  logic [DATA_WIDTH-1:0]      offset,
    input  logic                       use_offset,
    output logic [DATA_WIDTH-1:0]      result
);
    import avt_pkg::*;

    localparam int FULL_W = 2 * DATA_WIDTH;
    localparam int PROD_W = FULL_W - FRAC_BITS;
    localparam int ACC_W  = ((PROD_W > DATA_WIDTH) ? PROD_W : DATA_WIDTH) + 2;

    logic [2:0][DATA_WIDTH-1:0] vec_reg;
    logic [2:0][DATA_WIDTH-1:0] coeff_reg;
    logic [DATA_WIDTH-1:0]      offset_reg;
    logic                       use_offset_reg;

    logic signed [FULL_W-1:0]   full_prod [3];
    logic signed [PROD_W-1:0]   prod_next [3];
    logic signed [PROD_W-1:0]   prod_reg  [3];
    logic signed [ACC_W-1:0]    offset_next;
    logic signed [ACC_W-1:0]    offset_ext_reg;

    logic signed [ACC_W-1:0]    sum_next;
    logic signed [ACC_W-1:0]    sum_reg;
    logic [ACC_W-DATA_WIDTH:0]  sum_upper;

    // Capture operands
    always_ff @(posedge aclk) begin
        if (en.ld_op) begin
            vec_reg        <= vec;
            coeff_reg      <= coeff;
            offset_reg     <= offset;
            use_offset_reg <= use_offset;
        end
    end

    // Multiply and drop fraction bits (floor)
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            full_prod[j] = $signed(vec_reg[j]) * $signed(coeff_reg[j]);
            prod_next[j] = full_prod[j][FULL_W-1:FRAC_BITS];
        end
        offset_next = use_offset_reg ? ACC_W'($signed(offset_reg)) : '0;
    end

    always_ff @(posedge aclk) begin
        if (en.ld_prod) begin
            prod_reg       <= prod_next;
            offset_ext_reg <= offset_next;
        end
    end

    // Exact sum of the terms
    assign sum_next = ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1]) +
                      ACC_W'(prod_reg[2]) + offset_ext_reg;

    always_ff @(posedge aclk) begin
        if (en.ld_sum) begin
            sum_reg <= sum_next;
        end
    end

    // Saturate to the signed data range
    assign sum_upper = sum_reg[ACC_W-1:DATA_WIDTH-1];

    always_comb begin
        if ((&sum_upper) || !(|sum_upper)) begin
            result = sum_reg[DATA_WIDTH-1:0];
        end else if (sum_reg[ACC_W-1]) begin
            result = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            result = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

endmodule

// ===== tb/tb_affine_vector_transform.sv =====
// Self-checking testbench for the affine vector transform stream block.
// Depends on avt_pkg and the affine_vector_transform RTL; predicts each result
// from its own copy of both matrices and checks results in request order.
module tb_affine_vector_transform;
    timeunit 1ns;
    timeprecision 1ps;

    import avt_pkg::*;

    localparam int FRAC = DEF_FRAC_BITS;
    localparam int DW = DEF_DATA_WIDTH;
    localparam int S_W = ((IDX_W + 4 * DW + 7) / 8) * 8;
    localparam int M_W = ((3 * DW + 7) / 8) * 8;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;
    localparam int RANDOM_REQUESTS = 1950;
    localparam int CALM_FROM = 1750;
    localparam int LONG_HOLD_AT = 700;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 600000;

    localparam logic [DW-1:0] MAX_W = {1'b0, {(DW - 1){1'b1}}};
    localparam logic [DW-1:0] MIN_W = {1'b1, {(DW - 1){1'b0}}};
    localparam logic [DW-1:0] ONE_Q = 1 << FRAC;
    localparam logic [DW-1:0] NEG_LSB = '1;

    // Predicts transform results and holds them until the block returns them
    class transform_checker;
        logic signed [DW-1:0] fwd_m[NUM_COEFFS];
        logic signed [DW-1:0] inv_m[NUM_COEFFS];
        logic [M_W-1:0] pending_vectors[$];
        int mismatches;

        function new();
            for (int i = 0; i < NUM_COEFFS; i++) begin
                fwd_m[i] = (i % 4 == 0 && i < 9) ? ONE_Q : '0;
                inv_m[i] = (i % 4 == 0 && i < 9) ? ONE_Q : '0;
            end
            mismatches = 0;
        endfunction

        // Exact product, floored by the fraction bits
        function longint scaled_product(logic signed [DW-1:0] a, logic signed [DW-1:0] b);
            longint p;
            p = longint'(a) * longint'(b);
            return p >>> FRAC;
        endfunction

        function logic [DW-1:0] clamp(longint s);
            longint hi_lim;
            longint lo_lim;
            hi_lim = (longint'(1) << (DW - 1)) - 1;
            lo_lim = -(longint'(1) << (DW - 1));
            if (s > hi_lim) return MAX_W;
            if (s < lo_lim) return MIN_W;
            return s[DW-1:0];
        endfunction

        function void accept_request(logic [FUNC_W-1:0] kind, logic [S_W-1:0] d);
            logic [IDX_W-1:0] idx;
            logic signed [DW-1:0] coeff;
            logic signed [DW-1:0] vec[3];
            logic signed [DW-1:0] m[NUM_COEFFS];
            logic [M_W-1:0] result;
            longint acc;
            idx = d[IDX_W-1:0];
            coeff = d[IDX_W +: DW];
            for (int k = 0; k < 3; k++)
                vec[k] = d[IDX_W + (k + 1) * DW +: DW];
            case (kind)
                FUNC_LOAD_FWD: begin
                    if (idx < NUM_COEFFS) fwd_m[idx] = coeff;
                end
                FUNC_LOAD_INV: begin
                    if (idx < NUM_COEFFS) inv_m[idx] = coeff;
                end
                FUNC_FWD_PNT, FUNC_INV_PNT, FUNC_FWD_DIR, FUNC_INV_DIR, FUNC_NORMAL: begin
                    if (kind == FUNC_FWD_PNT || kind == FUNC_FWD_DIR) m = fwd_m;
                    else m = inv_m;
                    result = '0;
                    for (int c = 0; c < 3; c++) begin
                        if (kind == FUNC_NORMAL) begin
                            // transposed upper 3x3 of the inverse
                            acc = scaled_product(vec[0], m[c * 3])
                                + scaled_product(vec[1], m[c * 3 + 1])
                                + scaled_product(vec[2], m[c * 3 + 2]);
                        end else begin
                            acc = scaled_product(vec[0], m[c])
                                + scaled_product(vec[1], m[3 + c])
                                + scaled_product(vec[2], m[6 + c]);
                            if (kind == FUNC_FWD_PNT || kind == FUNC_INV_PNT)
                                acc += longint'(m[9 + c]);
                        end
                        result[c * DW +: DW] = clamp(acc);
                    end
                    pending_vectors.push_back(result);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [M_W-1:0] got);
            logic [M_W-1:0] want;
            if (pending_vectors.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h with nothing outstanding", got);
                return;
            end
            want = pending_vectors.pop_front();
            for (int k = 0; k < 3; k++) begin
                if (got[k * DW +: DW] !== want[k * DW +: DW]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("component %0d mismatch at %0t: expected %h, got %h",
                                 k, $realtime, want[k * DW +: DW], got[k * DW +: DW]);
                end
            end
        endfunction

        function int outstanding();
            return pending_vectors.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic [FUNC_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;

    transform_checker board = new();
    bit calm_tail = 1'b0;
    bit hold_pending = 1'b0;
    int cycle_count = 0;

    logic [DW-1:0] corner_words[5] = '{MAX_W, MIN_W, '0, NEG_LSB, ONE_Q};
    logic [FUNC_W-1:0] transform_kinds[5] =
        '{FUNC_FWD_PNT, FUNC_INV_PNT, FUNC_FWD_DIR, FUNC_INV_DIR, FUNC_NORMAL};

    affine_vector_transform dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Note accepted requests and check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.accept_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready) board.check_result(m_tdata);
        end
    end

    // Abort a run that hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold, none in the tail
    initial begin
        @(posedge aresetn);
        forever begin
            if (calm_tail) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if (hold_pending) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                hold_pending = 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    function automatic logic [S_W-1:0] pack_request(logic [IDX_W-1:0] idx, logic [DW-1:0] coeff,
                                                    logic [DW-1:0] x, logic [DW-1:0] y,
                                                    logic [DW-1:0] z);
        logic [S_W-1:0] d;
        d = '0;
        d[IDX_W-1:0] = idx;
        d[IDX_W +: DW] = coeff;
        d[IDX_W + DW +: DW] = x;
        d[IDX_W + 2 * DW +: DW] = y;
        d[IDX_W + 3 * DW +: DW] = z;
        return d;
    endfunction

    // Mostly small Q16.16 values so that sums stay in range, with corners and full words
    function automatic logic [DW-1:0] random_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return $urandom;
        if (pick == 1) return corner_words[$urandom_range(0, 4)];
        return DW'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endfunction

    // Offer one request, after an optional idle burst, and hold it until accepted
    task automatic send_request(logic [FUNC_W-1:0] kind, logic [S_W-1:0] d);
        if (!calm_tail && !hold_pending && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    initial begin
        logic [FUNC_W-1:0] kind;
        logic [IDX_W-1:0] idx;
        int pick;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Identity matrices with extreme operands
        send_request(FUNC_FWD_PNT, pack_request('0, '0, MAX_W, MIN_W, 32'h1));
        send_request(FUNC_INV_DIR, pack_request('0, '0, MIN_W, MAX_W, ONE_Q));
        send_request(FUNC_NORMAL, pack_request('0, '0, NEG_LSB, '0, MAX_W));
        // Unused code and out-of-range slots must leave everything alone
        send_request(FUNC_UNUSED, pack_request('1, MAX_W, MAX_W, MAX_W, MAX_W));
        send_request(FUNC_LOAD_FWD, pack_request(4'd12, MAX_W, '0, '0, '0));
        send_request(FUNC_LOAD_INV, pack_request(4'd15, MIN_W, '1, '1, '1));
        send_request(FUNC_FWD_PNT, pack_request('0, '0, ONE_Q, NEG_LSB, MIN_W));
        // Extreme forward coefficients, then overflow both ways
        send_request(FUNC_LOAD_FWD, pack_request(4'd0, MAX_W, '0, '0, '0));
        send_request(FUNC_LOAD_FWD, pack_request(4'd4, MIN_W, '0, '0, '0));
        send_request(FUNC_LOAD_FWD, pack_request(4'd9, MAX_W, '0, '0, '0));
        send_request(FUNC_LOAD_FWD, pack_request(4'd10, MIN_W, '0, '0, '0));
        send_request(FUNC_LOAD_FWD, pack_request(4'd11, NEG_LSB, '0, '0, '0));
        send_request(FUNC_FWD_PNT, pack_request('0, '0, MAX_W, MAX_W, MAX_W));
        send_request(FUNC_FWD_DIR, pack_request('0, '0, MIN_W, MAX_W, 32'h1));
        // Extreme inverse coefficients through point, direction and normal
        send_request(FUNC_LOAD_INV, pack_request(4'd2, MAX_W, '0, '0, '0));
        send_request(FUNC_LOAD_INV, pack_request(4'd3, MIN_W, '0, '0, '0));
        send_request(FUNC_LOAD_INV, pack_request(4'd11, ONE_Q, '0, '0, '0));
        send_request(FUNC_INV_PNT, pack_request('0, '0, MIN_W, MIN_W, MIN_W));
        send_request(FUNC_INV_DIR, pack_request('0, '0, MAX_W, MIN_W, NEG_LSB));
        send_request(FUNC_NORMAL, pack_request('0, '0, MIN_W, MAX_W, MAX_W));

        // Random requests: loads, transforms and the odd ignored request
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == LONG_HOLD_AT) hold_pending = 1'b1;
            if (n == CALM_FROM) calm_tail = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                kind = (pick < 10) ? FUNC_LOAD_FWD : FUNC_LOAD_INV;
                idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(12, 15))
                                                   : IDX_W'($urandom_range(0, NUM_COEFFS - 1));
            end else begin
                kind = (pick < 23) ? FUNC_UNUSED : transform_kinds[$urandom_range(0, 4)];
                idx = IDX_W'($urandom_range(0, 15));
            end
            send_request(kind, pack_request(idx, random_word(), random_word(),
                                            random_word(), random_word()));
        end
        s_tvalid <= 1'b0;

        // Drain, then allow the pipeline depth to flush out any stray result
        while (board.outstanding() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);

        if (board.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/avt_pkg.sv
design/avt_coeff_bank.sv
design/avt_dot_lane.sv
design/affine_vector_transform.sv
tb/tb_affine_vector_transform.sv
